>>> hdl/rvlsu_pkg.sv
// Shared types, defaults and access-width codes of the load/store unit.
package rvlsu_pkg;

	// Default number of word address bits of the data memory.
	localparam int unsigned WORD_ADDR_BITS_DEF = 14;

	// Load funct3 codes.
	localparam logic [2:0] LD_BYTE   = 3'b000;
	localparam logic [2:0] LD_HALF   = 3'b001;
	localparam logic [2:0] LD_WORD   = 3'b010;
	localparam logic [2:0] LD_BYTE_U = 3'b100;
	localparam logic [2:0] LD_HALF_U = 3'b101;

	// Store sizes, taken from the low two bits of funct3.
	localparam logic [1:0] ST_BYTE = 2'b00;
	localparam logic [1:0] ST_HALF = 2'b01;
	localparam logic [1:0] ST_WORD = 2'b10;

	// One instruction leaving the execute stage.
	typedef struct packed {
		logic               cancel_in;
		logic               is_load;
		logic               do_store;
		logic [2:0]         width_code;
		logic signed [31:0] exec_result;
		logic signed [31:0] store_data;
		logic [4:0]         dest_reg;
		logic               is_return;
		logic               no_dest;
	} req_beat_t;

	// One instruction handed on to writeback.
	typedef struct packed {
		logic               cancel_out;
		logic signed [31:0] wb_value;
		logic [4:0]         dest_reg_out;
		logic               is_return_out;
		logic               no_dest_out;
	} rsp_beat_t;

	// Lane selection for the byte-lane unit.
	typedef struct packed {
		logic [2:0] width_code;
		logic [1:0] byte_off;
	} lane_ctrl_t;

endpackage

>>> hdl/rv32i_load_store_unit.sv
// Memory stage of an RV32I pipeline: load/store unit with its own data memory.
//
//  Channel | Direction | Handshake             | Beat type
//  --------+-----------+-----------------------+----------------------
//  req     | in        | req_valid, req_stall  | rvlsu_pkg::req_beat_t
//  rsp     | out       | rsp_valid, rsp_stall  | rvlsu_pkg::rsp_beat_t
//
// One beat can be taken every cycle while req_stall is low; a taken beat passes through
// stage one and then the output register, from which its result is offered on rsp.
// The memory is read when a request is taken and written back when the stage-one beat
// moves to the output register; a merged word is forwarded to a directly following
// request to the same word.
// Reset clears only the valid flags; the memory holds no defined content.
// A stall on rsp holds the output register, then stage one, then req.
module rv32i_load_store_unit #(
	parameter int unsigned WORD_ADDR_BITS = rvlsu_pkg::WORD_ADDR_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  rvlsu_pkg::req_beat_t req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rvlsu_pkg::rsp_beat_t rsp
);

	localparam int unsigned AW = WORD_ADDR_BITS;

	logic                  valid_s1;
	rvlsu_pkg::req_beat_t  beat_s1;
	logic                  fwd_s1;
	logic [31:0]           fwd_word_s1;
	logic                  rsp_valid_q;
	rvlsu_pkg::rsp_beat_t  rsp_q;

	logic                  req_take;
	logic                  advance;
	logic [AW-1:0]         req_idx;
	logic [AW-1:0]         idx_s1;
	logic [31:0]           mem_rdata;
	logic [31:0]           cur_word;
	logic [31:0]           load_value;
	logic [31:0]           merged_word;
	logic                  store_hits;
	logic                  mem_we;
	logic [31:0]           wb_value;
	rvlsu_pkg::lane_ctrl_t lane_ctrl;

	// Handshake and word indexes.
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign req_take  = req_valid && !req_stall;
	assign req_idx   = req.exec_result[AW+1:2];
	assign idx_s1    = beat_s1.exec_result[AW+1:2];

	// Data memory.
	rvlsu_data_mem #(
		.ADDR_BITS(AW)
	) u_mem (
		.clk    (clk),
		.rd_en  (req_take),
		.rd_addr(req_idx),
		.rd_data(mem_rdata),
		.wr_en  (mem_we),
		.wr_addr(idx_s1),
		.wr_data(merged_word)
	);

	// Word seen by stage one, with the previous write forwarded.
	assign cur_word = fwd_s1 ? fwd_word_s1 : mem_rdata;

	always_comb begin
		lane_ctrl.width_code = beat_s1.width_code;
		lane_ctrl.byte_off   = beat_s1.exec_result[1:0];
	end

	rvlsu_lane_unit u_lane (
		.ctrl       (lane_ctrl),
		.word       (cur_word),
		.store_data (beat_s1.store_data),
		.load_value (load_value),
		.merged_word(merged_word),
		.store_hits (store_hits)
	);

	// Write back when the beat leaves stage one; cancelled beats touch nothing.
	assign mem_we = advance && beat_s1.do_store && !beat_s1.cancel_in && store_hits;

	always_comb begin
		if (beat_s1.cancel_in) begin
			wb_value = 32'd0;
		end else if (beat_s1.is_load) begin
			wb_value = load_value;
		end else begin
			wb_value = beat_s1.exec_result;
		end
	end

	// Valid flags of stage one and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Stage-one payload and forwarding of a same-word write.
	always_ff @(posedge clk) begin
		if (req_take) begin
			beat_s1     <= req;
			fwd_s1      <= mem_we && (idx_s1 == req_idx);
			fwd_word_s1 <= merged_word;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.cancel_out    <= beat_s1.cancel_in;
			rsp_q.wb_value      <= wb_value;
			rsp_q.dest_reg_out  <= beat_s1.dest_reg;
			rsp_q.is_return_out <= beat_s1.is_return;
			rsp_q.no_dest_out   <= beat_s1.no_dest;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_we_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> advance && !beat_s1.cancel_in)
		else $error("memory written without a live store leaving stage one");

	a_fwd_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> (fwd_s1 == $past(mem_we && (idx_s1 == req_idx))))
		else $error("forward flag does not match a same-word write at the take");

	a_cancel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.cancel_out) |-> (rsp.wb_value == 32'd0))
		else $error("cancelled beat carries a non-zero result");

	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s1) |-> $past(req_valid && !req_stall))
		else $error("stage one filled without a request beat");
`endif

endmodule

>>> hdl/rvlsu_data_mem.sv
// Synchronous word memory with one write port and one registered read port.
module rvlsu_data_mem #(
	parameter int unsigned ADDR_BITS = rvlsu_pkg::WORD_ADDR_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output logic [31:0]          rd_data,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  logic [31:0]          wr_data
);

	localparam int unsigned DEPTH = 1 << ADDR_BITS;

	logic [31:0] mem [DEPTH];
	logic [31:0] rd_data_q;

	// Read-first port: a read and a write of the same word in one cycle returns the old word.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hdl/rvlsu_lane_unit.sv
// Byte-lane extraction for loads and lane merging for stores.
module rvlsu_lane_unit (
	input  rvlsu_pkg::lane_ctrl_t ctrl,
	input  logic [31:0]           word,
	input  logic [31:0]           store_data,
	output logic [31:0]           load_value,
	output logic [31:0]           merged_word,
	output logic                  store_hits
);

	logic [7:0]  sel_byte;
	logic [15:0] sel_half;

	// Pick the addressed byte and halfword of the word.
	always_comb begin
		sel_byte = word[{ctrl.byte_off, 3'b000} +: 8];
		sel_half = ctrl.byte_off[1] ? word[31:16] : word[15:0];
	end

	// Extend the selected lane as funct3 asks; undefined codes give zero.
	always_comb begin
		case (ctrl.width_code)
			rvlsu_pkg::LD_BYTE:   load_value = {{24{sel_byte[7]}}, sel_byte};
			rvlsu_pkg::LD_HALF:   load_value = {{16{sel_half[15]}}, sel_half};
			rvlsu_pkg::LD_WORD:   load_value = word;
			rvlsu_pkg::LD_BYTE_U: load_value = {24'd0, sel_byte};
			rvlsu_pkg::LD_HALF_U: load_value = {16'd0, sel_half};
			default:              load_value = 32'd0;
		endcase
	end

	// Merge the store data into the addressed lanes; the fourth size code writes nothing.
	always_comb begin
		merged_word = word;
		store_hits  = 1'b1;
		case (ctrl.width_code[1:0])
			rvlsu_pkg::ST_BYTE: begin
				merged_word[{ctrl.byte_off, 3'b000} +: 8] = store_data[7:0];
			end
			rvlsu_pkg::ST_HALF: begin
				merged_word[{ctrl.byte_off[1], 4'b0000} +: 16] = store_data[15:0];
			end
			rvlsu_pkg::ST_WORD: begin
				merged_word = store_data;
			end
			default: begin
				store_hits = 1'b0;
			end
		endcase
	end

endmodule
